// ===== rtl/core/ring_fifo_overwrite_last_assert.svh =====
// Assertion macros shared by the ring FIFO modules.
`ifndef RING_FIFO_OVERWRITE_LAST_ASSERT_SVH
`define RING_FIFO_OVERWRITE_LAST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RFO_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring fifo assertion failed");

// Next-cycle implication, disabled during reset.
`define RFO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring fifo assertion failed");

`endif

// ===== rtl/core/rfo_pkg.sv =====
// Package with shared types and constants of the ring FIFO.
package rfo_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int NUM_ELEMS_RESET    = 16;

  localparam int OPCODE_W = 2;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
    logic cfg_write;
  } cmd_t;

endpackage

// ===== rtl/core/rfo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rfo_ram #(
  parameter int WIDTH = rfo_pkg::DATA_WIDTH_DEFAULT,
  parameter int DEPTH = rfo_pkg::DEPTH_DEFAULT,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rfo_ctrl.sv =====
// Controller state machine: sequences accept, execute and respond phases.
`include "ring_fifo_overwrite_last_assert.svh"

module rfo_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  output logic         done,
  output rfo_pkg::cmd_t cmd
);

  rfo_pkg::state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      rfo_pkg::ST_IDLE: begin
        if (start) begin
          state_next = rfo_pkg::ST_EXEC;
        end
      end
      rfo_pkg::ST_EXEC: state_next = rfo_pkg::ST_RESP;
      rfo_pkg::ST_RESP: state_next = rfo_pkg::ST_IDLE;
      default:          state_next = rfo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfo_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == rfo_pkg::ST_RESP);
    end
  end

  assign busy          = (state != rfo_pkg::ST_IDLE);
  assign cfg_ready     = (state == rfo_pkg::ST_IDLE) && !start;
  assign cmd.load      = start && !busy;
  assign cmd.exec      = (state == rfo_pkg::ST_EXEC);
  assign cmd.respond   = (state == rfo_pkg::ST_RESP);
  assign cmd.cfg_write = cfg_valid && cfg_ready;

  `RFO_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `RFO_ASSERT_NEXT(a_resp_done, clk, rst, cmd.respond, done && !busy)
  `RFO_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `RFO_ASSERT_NOW(a_cfg_idle, clk, rst, cmd.cfg_write, !busy && !cmd.load)

endmodule

// ===== rtl/core/rfo_dp.sv =====
// Datapath: pointers, overflow flag, slot RAM and result registers.
`include "ring_fifo_overwrite_last_assert.svh"

module rfo_dp #(
  parameter int DEPTH      = rfo_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rfo_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rfo_pkg::cmd_t                cmd,
  input  logic [rfo_pkg::OPCODE_W-1:0] opcode,
  input  logic [rfo_pkg::WORD_W-1:0]   write_data,
  input  logic [rfo_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                         done,
  output logic [rfo_pkg::WORD_W-1:0]   read_data,
  output logic                         read_valid,
  output logic                         overwrote,
  output logic [rfo_pkg::COUNT_W-1:0]  used_count,
  output logic [rfo_pkg::COUNT_W-1:0]  free_count,
  output logic                         is_empty,
  output logic                         is_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int RESET_SIZE =
    (rfo_pkg::NUM_ELEMS_RESET > DEPTH) ? DEPTH : rfo_pkg::NUM_ELEMS_RESET;

  logic [CNT_W-1:0]      ring_size;
  logic [PTR_W-1:0]      wp, rp, wp_next, rp_next;
  logic                  flag, flag_next;
  rfo_pkg::op_t          op_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  logic                  over_q, over_next;
  logic                  rvalid_q, rvalid_next;
  logic                  we;
  logic [PTR_W-1:0]      waddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [CNT_W-1:0]      size_next;
  logic [PTR_W-1:0]      adv_wp, adv_wp2, adv_rp;
  logic [CNT_W-1:0]      used;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(1);
    return (s >= SUM_W'(n)) ? '0 : PTR_W'(s);
  endfunction

  always_comb begin
    if (cfg_data == '0) begin
      size_next = CNT_W'(1);
    end else if (32'(cfg_data) > DEPTH) begin
      size_next = CNT_W'(DEPTH);
    end else begin
      size_next = CNT_W'(cfg_data);
    end
  end

  assign adv_wp  = adv(wp, ring_size);
  assign adv_wp2 = adv(adv_wp, ring_size);
  assign adv_rp  = adv(rp, ring_size);

  always_comb begin
    wp_next     = wp;
    rp_next     = rp;
    flag_next   = flag;
    over_next   = 1'b0;
    rvalid_next = 1'b0;
    we          = 1'b0;
    waddr       = wp;
    unique case (op_q)
      rfo_pkg::OP_PUT: begin
        we = 1'b1;
        if (adv_wp == rp) begin
          over_next = flag;
          flag_next = 1'b1;
        end else if (flag) begin
          waddr = adv_wp;
          if (adv_wp2 != rp) begin
            flag_next = 1'b0;
            wp_next   = adv_wp2;
          end else begin
            wp_next = adv_wp;
          end
        end else begin
          wp_next = adv_wp;
        end
      end
      rfo_pkg::OP_GET: begin
        if (wp == rp) begin
          if (flag) begin
            rvalid_next = 1'b1;
            flag_next   = 1'b0;
          end
        end else begin
          rvalid_next = 1'b1;
          rp_next     = adv_rp;
        end
      end
      rfo_pkg::OP_FLUSH: begin
        rp_next   = wp;
        flag_next = 1'b0;
      end
      rfo_pkg::OP_STATUS: begin
      end
      default: begin
      end
    endcase
  end

  rfo_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && we),
    .waddr (waddr),
    .wdata (wdata_q),
    .re    (cmd.exec),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= CNT_W'(RESET_SIZE);
      wp        <= '0;
      rp        <= '0;
      flag      <= 1'b0;
    end else if (cmd.cfg_write) begin
      ring_size <= size_next;
      wp        <= '0;
      rp        <= '0;
      flag      <= 1'b0;
    end else if (cmd.exec) begin
      wp   <= wp_next;
      rp   <= rp_next;
      flag <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= rfo_pkg::op_t'(opcode);
      wdata_q <= DATA_WIDTH'(write_data);
    end
    if (cmd.exec) begin
      over_q   <= over_next;
      rvalid_q <= rvalid_next;
    end
  end

  assign used = CNT_W'(wp) - CNT_W'(rp) + ((wp < rp) ? ring_size : '0) + CNT_W'(flag);

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      read_data  <= rvalid_q ? rfo_pkg::WORD_W'(ram_rdata) : '0;
      read_valid <= rvalid_q;
      overwrote  <= over_q;
      used_count <= rfo_pkg::COUNT_W'(used);
      free_count <= rfo_pkg::COUNT_W'(ring_size - used);
      is_empty   <= (wp == rp) && !flag;
      is_full    <= (adv_wp == rp) && flag;
    end
  end

  `RFO_ASSERT_NOW(a_ptr_range, clk, rst, 1'b1,
    (CNT_W'(wp) < ring_size) && (CNT_W'(rp) < ring_size))
  `RFO_ASSERT_NOW(a_used_range, clk, rst, 1'b1, used <= ring_size)
  `RFO_ASSERT_NOW(a_empty_full, clk, rst, done, !(is_empty && is_full))

endmodule

// ===== rtl/core/ring_fifo_overwrite_last.sv =====
// Top level of the ring FIFO with overwrite of the newest element.
//
// Command channel: drive opcode and write_data with start; the beat is taken
// at a rising edge where start is high and busy is low. Opcodes: put, get,
// flush, status query. Each command yields exactly one result beat.
// Result channel: done is high for one cycle with read_data, read_valid,
// overwrote, used_count, free_count, is_empty and is_full; the receiver must
// take it in that cycle, it cannot hold results off.
// Configuration: cfg_data (num_elems) is written when cfg_valid and cfg_ready
// are both high; cfg_ready is high only while idle. A write also empties the
// queue. Values of 0 act as 1, values above DEPTH act as DEPTH.
// Sequence: after the accepting edge the controller steps through the execute
// and respond states with busy high, and done is registered from the respond
// state; the result beat is taken at the edge that ends it. No new command is
// taken while busy; results pass the registered slot RAM read port and result stage.
// Reset (rst, synchronous): pointers and overflow flag clear, num_elems = 16
// (clamped to DEPTH); slot contents are not cleared and need no sweep.
module ring_fifo_overwrite_last #(
  parameter int DEPTH      = rfo_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rfo_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rfo_pkg::OPCODE_W-1:0] opcode,
  input  logic [rfo_pkg::WORD_W-1:0]   write_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rfo_pkg::COUNT_W-1:0]  cfg_data,
  output logic                         done,
  output logic [rfo_pkg::WORD_W-1:0]   read_data,
  output logic                         read_valid,
  output logic                         overwrote,
  output logic [rfo_pkg::COUNT_W-1:0]  used_count,
  output logic [rfo_pkg::COUNT_W-1:0]  free_count,
  output logic                         is_empty,
  output logic                         is_full
);

  rfo_pkg::cmd_t cmd;

  rfo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .done      (done),
    .cmd       (cmd)
  );

  rfo_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (opcode),
    .write_data (write_data),
    .cfg_data   (cfg_data),
    .done       (done),
    .read_data  (read_data),
    .read_valid (read_valid),
    .overwrote  (overwrote),
    .used_count (used_count),
    .free_count (free_count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the ring FIFO with overwrite of the newest element.
`timescale 1ns / 1ps

module testbench;
  import rfo_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int QUIET_PHASE = 3;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic valid;
    logic over;
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] free;
    logic empty;
    logic full;
  } fifo_reply_t;

  class fifo_scoreboard;
    logic [COUNT_W-1:0] ring_size_reg = COUNT_W'(NUM_ELEMS_RESET);
    int unsigned wr_idx = 0;
    int unsigned rd_idx = 0;
    bit held_at_wr = 1'b0;
    logic [WORD_W-1:0] slots [DEPTH];
    fifo_reply_t reply_q[$];
    int errors = 0;

    function int unsigned ring_len();
      if (ring_size_reg == 0) return 1;
      if (ring_size_reg > DEPTH) return DEPTH;
      return ring_size_reg;
    endfunction

    function int unsigned next_slot(int unsigned p, int unsigned n);
      return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    function void set_ring_size(logic [COUNT_W-1:0] size);
      ring_size_reg = size;
      wr_idx = 0;
      rd_idx = 0;
      held_at_wr = 1'b0;
    endfunction

    function void note_command(op_t op, logic [WORD_W-1:0] word);
      fifo_reply_t r;
      int unsigned n;
      int unsigned used;
      n = ring_len();
      r = '0;
      if (wr_idx >= n) wr_idx = 0;
      if (rd_idx >= n) rd_idx = 0;
      case (op)
        OP_PUT: begin
          if (next_slot(wr_idx, n) == rd_idx) begin
            r.over = held_at_wr;
            held_at_wr = 1'b1;
          end else if (held_at_wr) begin
            wr_idx = next_slot(wr_idx, n);
            if (next_slot(wr_idx, n) != rd_idx) held_at_wr = 1'b0;
          end
          slots[wr_idx] = word;
          if (!held_at_wr) wr_idx = next_slot(wr_idx, n);
        end
        OP_GET: begin
          if (wr_idx != rd_idx || held_at_wr) begin
            r.data = slots[rd_idx];
            r.valid = 1'b1;
            if (wr_idx == rd_idx) held_at_wr = 1'b0;
            else rd_idx = next_slot(rd_idx, n);
          end
        end
        OP_FLUSH: begin
          rd_idx = wr_idx;
          held_at_wr = 1'b0;
        end
        OP_STATUS: ;
      endcase
      used = ((wr_idx >= rd_idx) ? wr_idx - rd_idx : n + wr_idx - rd_idx) + held_at_wr;
      r.used = COUNT_W'(used);
      r.free = COUNT_W'(n - used);
      r.empty = (wr_idx == rd_idx) && !held_at_wr;
      r.full = (next_slot(wr_idx, n) == rd_idx) && held_at_wr;
      reply_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(fifo_reply_t got);
      fifo_reply_t want;
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", got));
      end else begin
        want = reply_q.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "data %h/%h valid %b/%b over %b/%b used %0d/%0d free %0d/%0d empty %b/%b full %b/%b",
            got.data, want.data, got.valid, want.valid, got.over, want.over,
            got.used, want.used, got.free, want.free, got.empty, want.empty,
            got.full, want.full));
        end
      end
    endtask

    function int pending();
      return reply_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OPCODE_W-1:0] opcode = '0;
  logic [WORD_W-1:0] write_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic done;
  logic [WORD_W-1:0] read_data;
  logic read_valid;
  logic overwrote;
  logic [COUNT_W-1:0] used_count;
  logic [COUNT_W-1:0] free_count;
  logic is_empty;
  logic is_full;

  fifo_scoreboard sb = new();
  int cycles = 0;

  ring_fifo_overwrite_last u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .write_data(write_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .read_data(read_data), .read_valid(read_valid),
    .overwrote(overwrote), .used_count(used_count), .free_count(free_count),
    .is_empty(is_empty), .is_full(is_full)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_result({read_data, read_valid, overwrote, used_count, free_count,
                         is_empty, is_full});
      end
      if (start && !busy) sb.note_command(op_t'(opcode), write_data);
      if (cfg_valid && cfg_ready) sb.set_ring_size(cfg_data);
    end
  end

  task automatic issue(op_t op, logic [WORD_W-1:0] word);
    start <= 1'b1;
    opcode <= op;
    write_data <= word;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_fifo();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ring_size(logic [COUNT_W-1:0] size);
    drain_fifo();
    cfg_valid <= 1'b1;
    cfg_data <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(bit quiet);
    int put_pct;
    int roll;
    op_t op;
    logic [WORD_W-1:0] word;
    put_pct = 50;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (i % 20 == 0) put_pct = $urandom_range(25, 75);
      if (i == ITEMS_PER_PHASE / 2) begin
        drain_fifo();
      end else if (!quiet && $urandom_range(99) < 19) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      roll = $urandom_range(99);
      if (roll < put_pct) begin
        op = OP_PUT;
      end else begin
        roll = $urandom_range(99);
        if (roll < 70) op = OP_GET;
        else if (roll < 85) op = OP_STATUS;
        else op = OP_FLUSH;
      end
      roll = $urandom_range(19);
      if (roll == 0) word = '0;
      else if (roll == 1) word = '1;
      else word = $urandom();
      issue(op, word);
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] sizes [PHASES];
    sizes = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd2, 5'd0, 5'd0, 5'd16};
    sizes[7] = COUNT_W'($urandom_range(1, 16));
    sizes[8] = COUNT_W'($urandom_range(3, 15));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(OP_STATUS, 32'h1234_5678);
    issue(OP_GET, '0);
    issue(OP_PUT, '0);
    issue(OP_PUT, '1);
    issue(OP_GET, '0);
    issue(OP_GET, '0);
    issue(OP_GET, '0);
    issue(OP_FLUSH, '1);

    write_ring_size(5'd2);
    issue(OP_PUT, 32'hA5A5_0001);
    issue(OP_PUT, 32'h5A5A_0002);
    issue(OP_PUT, 32'hDEAD_0003);
    issue(OP_GET, '0);
    issue(OP_PUT, 32'hBEEF_0004);
    issue(OP_GET, '0);
    issue(OP_GET, '0);
    issue(OP_GET, '0);
    issue(OP_PUT, 32'h8000_0001);
    issue(OP_FLUSH, '0);

    write_ring_size(5'd1);
    issue(OP_PUT, 32'h0F0F_0F0F);
    issue(OP_PUT, 32'hF0F0_F0F0);
    issue(OP_GET, '0);
    issue(OP_GET, '0);
    issue(OP_STATUS, '0);

    for (int p = 0; p < PHASES; p++) begin
      write_ring_size(sizes[p]);
      run_random_phase(p == QUIET_PHASE);
    end

    drain_fifo();
    if (sb.pending() != 0) sb.report_mismatch("expected results left over");
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
